/* src/scanline_scroll_timing_unit_top_assert.svh */
// Assertion macros for the scanline scroll timing unit.
`ifndef SCANLINE_SCROLL_TIMING_UNIT_TOP_ASSERT_SVH
`define SCANLINE_SCROLL_TIMING_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define SST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanline scroll timing check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define SST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanline scroll timing check failed");

`endif

/* src/sst_pkg.sv */
// Shared types and constants for the scanline scroll timing unit.
package sst_pkg;

  localparam int LINE_W  = 9;
  localparam int ADDR_W  = 15;
  localparam int VADDR_W = 14;
  localparam int COLOR_W = 5;

  localparam logic [LINE_W-1:0] VISIBLE_LINES = 9'd240;
  localparam logic [LINE_W-1:0] VBLANK_LINE   = 9'd241;
  localparam logic [LINE_W-1:0] LINES_RESET   = 9'd262;

  // Coarse X and the horizontal nametable bit.
  localparam logic [ADDR_W-1:0] HCOPY_MASK    = 15'h041F;
  localparam logic [2:0]        FINE_Y_LAST   = 3'd7;
  localparam logic [4:0]        COARSE_Y_LAST = 5'd29;
  localparam logic [5:0]        PALETTE_PAGE  = 6'h3F;

  typedef struct packed {
    logic               display_on;
    logic [ADDR_W-1:0]  scroll_latch;
    logic [VADDR_W-1:0] vram_address;
  } item_t;

  typedef struct packed {
    logic [LINE_W-1:0]  line_number;
    logic               render_line;
    logic [ADDR_W-1:0]  render_address;
    logic               fill_line;
    logic [COLOR_W-1:0] fill_color;
    logic               set_vblank;
    logic               clear_status;
    logic               last_line;
  } result_t;

endpackage

/* src/sst_step.sv */
// Per-scanline update of the line counter and scroll address, and its result.
module sst_step (
  input  logic [sst_pkg::LINE_W-1:0] line_counter,
  input  logic [sst_pkg::ADDR_W-1:0] scroll_address,
  input  logic [sst_pkg::LINE_W-1:0] lines_per_frame,
  input  sst_pkg::item_t             item,
  output sst_pkg::result_t           result,
  output logic [sst_pkg::LINE_W-1:0] line_counter_next,
  output logic [sst_pkg::ADDR_W-1:0] scroll_address_next
);
  import sst_pkg::*;

  logic              visible;
  logic [ADDR_W-1:0] copied;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] advanced;
  logic [ADDR_W-1:0] scroll_after;
  logic [2:0]        fine_y;
  logic [4:0]        coarse_y;
  logic [LINE_W-1:0] count_inc;
  logic              clear_hit;
  logic              wrap_hit;

  always_comb begin
    visible  = line_counter < VISIBLE_LINES;
    copied   = (scroll_address & ~HCOPY_MASK) | (item.scroll_latch & HCOPY_MASK);
    base     = (visible && item.display_on) ? copied : scroll_address;
    fine_y   = base[14:12];
    coarse_y = base[9:5];

    // Fine Y rolls into coarse Y; coarse Y 29 -> 0 flips the vertical
    // nametable, and coarse Y 31 simply wraps to 0.
    if (fine_y != FINE_Y_LAST) begin
      advanced = {fine_y + 3'd1, base[11:0]};
    end else if (coarse_y == COARSE_Y_LAST) begin
      advanced = {3'd0, ~base[11], base[10], 5'd0, base[4:0]};
    end else begin
      advanced = {3'd0, base[11:10], coarse_y + 5'd1, base[4:0]};
    end
    scroll_after = visible ? advanced : scroll_address;

    count_inc = line_counter + 9'd1;
    clear_hit = count_inc == (lines_per_frame - 9'd1);
    wrap_hit  = !clear_hit && (count_inc == lines_per_frame);

    scroll_address_next = (wrap_hit && item.display_on) ? item.scroll_latch : scroll_after;
    line_counter_next   = wrap_hit ? '0 : count_inc;

    result.line_number    = line_counter;
    result.render_line    = visible && item.display_on;
    result.render_address = (visible && item.display_on) ? copied : '0;
    result.fill_line      = visible && !item.display_on;
    result.fill_color     = (visible && !item.display_on
                             && item.vram_address[13:8] == PALETTE_PAGE)
                            ? item.vram_address[4:0] : '0;
    result.set_vblank     = count_inc == VBLANK_LINE;
    result.clear_status   = clear_hit;
    result.last_line      = wrap_hit;
  end

endmodule

/* src/scanline_scroll_timing_unit_top.sv */
// Top level of the scanline scroll timing unit: input register, update logic, result register.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready   | display_on, scroll_latch, vram_address
//   out     | output    | out_valid/out_ready | line_number ... last_line
//   cfg     | input     | cfg_we              | cfg_wdata (lines_per_frame)
//
// One transaction per cycle is sustained while out_ready stays high; a result passes through
// the input register and then the result register before it reaches the outputs.
// The line counter and scroll address update as an item moves from the input
// register to the result register, so the next item sees them at once.
// Reset (rst, synchronous) clears both registers' valid flags and the state,
// and loads lines_per_frame with 262. A stalled output holds its result while
// one more transaction waits in the input register.
`include "scanline_scroll_timing_unit_top_assert.svh"

module scanline_scroll_timing_unit_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        display_on,
  input  logic [sst_pkg::ADDR_W-1:0]  scroll_latch,
  input  logic [sst_pkg::VADDR_W-1:0] vram_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sst_pkg::LINE_W-1:0]  line_number,
  output logic                        render_line,
  output logic [sst_pkg::ADDR_W-1:0]  render_address,
  output logic                        fill_line,
  output logic [sst_pkg::COLOR_W-1:0] fill_color,
  output logic                        set_vblank,
  output logic                        clear_status,
  output logic                        last_line,
  input  logic                        cfg_we,
  input  logic [sst_pkg::LINE_W-1:0]  cfg_wdata
);
  import sst_pkg::*;

  logic [LINE_W-1:0] lines_per_frame;
  logic [LINE_W-1:0] line_counter;
  logic [LINE_W-1:0] line_counter_next;
  logic [ADDR_W-1:0] scroll_address;
  logic [ADDR_W-1:0] scroll_address_next;
  item_t             held_item;
  logic              held_valid;
  result_t           step_result;
  result_t           out_result;
  logic              advance;

  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  sst_step u_step (
    .line_counter        (line_counter),
    .scroll_address      (scroll_address),
    .lines_per_frame     (lines_per_frame),
    .item                (held_item),
    .result              (step_result),
    .line_counter_next   (line_counter_next),
    .scroll_address_next (scroll_address_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lines_per_frame <= LINES_RESET;
      line_counter    <= '0;
      scroll_address  <= '0;
      held_valid      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        lines_per_frame <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        line_counter   <= line_counter_next;
        scroll_address <= scroll_address_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item.display_on   <= display_on;
      held_item.scroll_latch <= scroll_latch;
      held_item.vram_address <= vram_address;
    end
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign line_number    = out_result.line_number;
  assign render_line    = out_result.render_line;
  assign render_address = out_result.render_address;
  assign fill_line      = out_result.fill_line;
  assign fill_color     = out_result.fill_color;
  assign set_vblank     = out_result.set_vblank;
  assign clear_status   = out_result.clear_status;
  assign last_line      = out_result.last_line;

  `SST_ASSERT_NOW(a_render_fill_excl, out_valid, !(render_line && fill_line))
  `SST_ASSERT_NOW(a_visible_only, out_valid && (render_line || fill_line), line_number < VISIBLE_LINES)
  `SST_ASSERT_NEXT(a_wrap_to_zero, advance && step_result.last_line, line_counter == '0)
  `SST_ASSERT_NOW(a_stall_has_item, !in_ready, held_valid && out_valid)

endmodule
